>>> rtl/core/tlpt_pkg.sv
// shared types and constants for the two-level page table manager
`timescale 1ns / 1ps
package tlpt_pkg;

  localparam int unsigned DirEntries = 1024;
  localparam int unsigned TableSlots = 8;
  localparam int unsigned TblEntries = 1024;
  localparam int unsigned DirW       = $clog2(DirEntries);
  localparam int unsigned SlotW      = $clog2(TableSlots);
  localparam int unsigned SlotCntW   = $clog2(TableSlots + 1);
  localparam int unsigned TblW       = $clog2(TblEntries);
  localparam int unsigned PtAddrW    = SlotW + TblW;

  typedef enum logic [1:0] {
    CmdMap   = 2'd0,
    CmdUnmap = 2'd1,
    CmdCheck = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    StDone     = 2'd0,
    StNoTable  = 2'd1,
    StNotThere = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] virt_addr;
    logic [31:0] phys_addr;
    logic [11:0] page_flags;
    logic [31:0] range_length;
    logic [19:0] new_table_frame;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        range_ok;
    logic        table_frame_used;
    logic        free_frame_valid;
    logic [19:0] freed_frame;
    logic        inval_req;
  } rsp_t;

  // directory entry as kept in memory: present, user, slot
  typedef struct packed {
    logic             present;
    logic             user;
    logic [SlotW-1:0] slot;
  } pde_t;

  // directory port bundle
  typedef struct packed {
    logic             we;
    logic [DirW-1:0]  addr;
    pde_t             wdata;
  } dir_req_t;

  // page table port bundle
  typedef struct packed {
    logic               we;
    logic [PtAddrW-1:0] addr;
    logic [31:0]        wdata;
  } pt_req_t;

endpackage

>>> rtl/core/tlpt_dir_mem.sv
// page directory memory, one read or write port, registered read data
`timescale 1ns / 1ps
module tlpt_dir_mem (
  input  logic               clk_i,
  input  tlpt_pkg::dir_req_t req_i,
  output tlpt_pkg::pde_t     rdata_o
);
  import tlpt_pkg::*;

  pde_t mem_q [DirEntries];
  pde_t rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) mem_q[req_i.addr] <= req_i.wdata;
    rd_q <= mem_q[req_i.addr];
  end

  assign rdata_o = rd_q;

endmodule

>>> rtl/core/tlpt_pt_mem.sv
// page table store memory, one read or write port, registered read data
`timescale 1ns / 1ps
module tlpt_pt_mem (
  input  logic              clk_i,
  input  tlpt_pkg::pt_req_t req_i,
  output logic [31:0]       rdata_o
);
  import tlpt_pkg::*;

  logic [31:0] mem_q [TableSlots*TblEntries];
  logic [31:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) mem_q[req_i.addr] <= req_i.wdata;
    rd_q <= mem_q[req_i.addr];
  end

  assign rdata_o = rd_q;

endmodule

>>> rtl/core/two_level_page_table_manager.sv
// top level: command sequencer for the two-level page table manager
//
//  channel | dir | handshake           | payload
//  req     | in  | req_valid_i/ready_o | tlpt_pkg::req_t
//  rsp     | out | rsp_valid_o/ready_i | tlpt_pkg::rsp_t
//
// map and unmap: after accept the steps are directory read, table read, write, respond
// dropped map or unmap without directory entry: responds right after the directory read
// check: directory read then table read per page walked; empty or wrapping range and unused command: respond at once
// after reset a pass over all 8192 table entries writes kernel entry, identity map and zeros; ready stays low
// slots never return to the pool, so a new table is still zero from that pass
// a finished result waits in the output register; the next item is taken once it has left
`timescale 1ns / 1ps
module two_level_page_table_manager (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  tlpt_pkg::req_t  req_i,
  output logic            rsp_valid_o,
  input  logic            rsp_ready_i,
  output tlpt_pkg::rsp_t  rsp_o
);
  import tlpt_pkg::*;

  typedef enum logic [2:0] {
    SInit, SIdle, SDirRd, SPtRd, SPtWr, SChkDir, SChkPt, SDone
  } state_e;

  state_e              state_q;
  req_t                req_q;
  rsp_t                rsp_q;
  logic                rsp_valid_q;
  logic [SlotCntW-1:0] next_slot_q;
  logic [31:0]         addr_q, last_q;
  pde_t                pde_q;
  logic [PtAddrW-1:0]  init_cnt_q;

  dir_req_t      dreq;
  pt_req_t       preq;
  pde_t          dir_rd;
  logic [31:0]   pt_rd;

  tlpt_dir_mem u_dir (
    .clk_i, .req_i(dreq), .rdata_o(dir_rd)
  );
  tlpt_pt_mem u_pt (
    .clk_i, .req_i(preq), .rdata_o(pt_rd)
  );

  logic accept;
  assign req_ready_o = (state_q == SIdle) && !rsp_valid_q;
  assign accept      = req_valid_i && req_ready_o;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  logic [32:0] end_sum;
  assign end_sum = {1'b0, req_i.virt_addr} + {1'b0, req_i.range_length};

  // check starts optimistic unless the range wraps; empty range passes at once
  logic chk_ok0;
  assign chk_ok0 = (req_i.command == CmdCheck)
                && ((req_i.range_length == '0) || !end_sum[32]);

  // memory port drive; during a walk the directory read runs one page ahead
  logic [31:0] cur_va;
  assign cur_va = (state_q == SIdle) ? req_i.virt_addr
                : (state_q == SChkDir) ? addr_q
                : (state_q == SChkPt) ? (addr_q + 32'h1000) : req_q.virt_addr;

  logic        new_tbl;
  logic        free_ok;
  assign free_ok = (req_q.new_table_frame != '0) && (next_slot_q < SlotCntW'(TableSlots));
  assign new_tbl = !dir_rd.present;

  always_comb begin
    dreq       = '0;
    dreq.addr  = cur_va[31:22];
    preq       = '0;
    // walk reads the table with the slot that just came out of the directory
    preq.addr  = {((state_q == SChkDir) ? dir_rd.slot : pde_q.slot), cur_va[21:12]};
    if (state_q == SInit) begin
      dreq.addr  = init_cnt_q[DirW-1:0];
      dreq.we    = (init_cnt_q[PtAddrW-1:DirW] == '0);
      dreq.wdata = '{present: (init_cnt_q == '0), user: 1'b0, slot: '0};
      preq.addr  = init_cnt_q;
      preq.we    = 1'b1;
      preq.wdata = (init_cnt_q[PtAddrW-1:TblW] == '0)
                 ? {10'd0, init_cnt_q[TblW-1:0], 12'h003} : 32'd0;
    end
    if (state_q == SDirRd && req_q.command == CmdMap) begin
      if (new_tbl && free_ok) begin
        dreq.we    = 1'b1;
        dreq.wdata = '{present: 1'b1, user: req_q.page_flags[2],
                       slot: next_slot_q[SlotW-1:0]};
      end else if (!new_tbl && req_q.page_flags[2]) begin
        dreq.we    = 1'b1;
        dreq.wdata = '{present: 1'b1, user: 1'b1, slot: dir_rd.slot};
      end
    end
    if (state_q == SPtWr) begin
      if (req_q.command == CmdMap) begin
        preq.we    = 1'b1;
        preq.wdata = {req_q.phys_addr[31:12], req_q.page_flags | 12'h001};
      end else if (pt_rd[0]) begin
        preq.we    = 1'b1;
        preq.wdata = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SInit;
      rsp_valid_q <= 1'b0;
      next_slot_q <= SlotCntW'(1);
      init_cnt_q  <= '0;
      req_q       <= '0;
      rsp_q       <= '0;
      addr_q      <= '0;
      last_q      <= '0;
      pde_q       <= '0;
    end else begin
      if (rsp_valid_q && rsp_ready_i) rsp_valid_q <= 1'b0;
      unique case (state_q)
        SInit: begin
          init_cnt_q <= init_cnt_q + PtAddrW'(1);
          if (init_cnt_q == '1) state_q <= SIdle;
        end
        SIdle: if (accept) begin
          req_q  <= req_i;
          rsp_q  <= '{status: StDone, range_ok: chk_ok0, table_frame_used: 1'b0,
                      free_frame_valid: 1'b0, freed_frame: '0, inval_req: 1'b0};
          addr_q <= {req_i.virt_addr[31:12], 12'd0};
          last_q <= (req_i.virt_addr + req_i.range_length - 32'd1) & 32'hFFFF_F000;
          if (req_i.command == CmdCheck) begin
            if (req_i.range_length == '0 || end_sum[32]) begin
              state_q <= SDone;
            end else begin
              state_q <= SChkDir;
            end
          end else if (req_i.command == CmdMap || req_i.command == CmdUnmap) begin
            state_q <= SDirRd;
          end else begin
            state_q <= SDone;
          end
        end
        SDirRd: begin
          if (req_q.command == CmdMap) begin
            if (new_tbl) begin
              if (free_ok) begin
                pde_q <= '{present: 1'b1, user: req_q.page_flags[2],
                           slot: next_slot_q[SlotW-1:0]};
                next_slot_q <= next_slot_q + SlotCntW'(1);
                rsp_q.table_frame_used <= 1'b1;
                state_q <= SPtRd;
              end else begin
                rsp_q.status <= StNoTable;
                state_q <= SDone;
              end
            end else begin
              pde_q   <= dir_rd;
              state_q <= SPtRd;
            end
          end else if (!dir_rd.present) begin
            rsp_q.status <= StNotThere;
            state_q <= SDone;
          end else begin
            pde_q   <= dir_rd;
            state_q <= SPtRd;
          end
        end
        SPtRd: state_q <= SPtWr;
        SPtWr: begin
          if (req_q.command == CmdUnmap) begin
            if (pt_rd[0]) begin
              rsp_q <= '{status: StDone, range_ok: 1'b0, table_frame_used: 1'b0,
                         free_frame_valid: 1'b1, freed_frame: pt_rd[31:12],
                         inval_req: 1'b1};
            end else begin
              rsp_q.status <= StNotThere;
            end
          end
          state_q <= SDone;
        end
        SChkDir: begin
          if (!dir_rd.present || !dir_rd.user) begin
            rsp_q.range_ok <= 1'b0;
            state_q <= SDone;
          end else begin
            state_q <= SChkPt;
          end
        end
        SChkPt: begin
          if (!pt_rd[0] || !pt_rd[2]) begin
            rsp_q.range_ok <= 1'b0;
            state_q <= SDone;
          end else if (addr_q == last_q) begin
            state_q <= SDone;
          end else begin
            addr_q  <= addr_q + 32'h1000;
            state_q <= SChkDir;
          end
        end
        SDone: begin
          rsp_valid_q <= 1'b1;
          state_q     <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_ready_o |-> (state_q == SIdle)) else $error("ready outside idle");
  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_slot_q <= SlotCntW'(TableSlots)) else $error("slot count overflow");
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SDone) |=> rsp_valid_q) else $error("result lost");
`endif

endmodule

>>> test/tlpt_checker.sv
// checker: predicts page table manager results and compares them on the response channel
`timescale 1ns / 1ps
module tlpt_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  input  logic           req_ready_i,
  input  tlpt_pkg::req_t req_i,
  input  logic           rsp_valid_i,
  input  logic           rsp_ready_i,
  input  tlpt_pkg::rsp_t rsp_i,
  output int unsigned    fail_count_o,
  output int unsigned    pending_o
);
  import tlpt_pkg::*;

  logic             dir_present [DirEntries];
  logic             dir_user    [DirEntries];
  logic [SlotW-1:0] dir_slot    [DirEntries];
  logic [31:0]      pte_mem     [TableSlots*TblEntries];
  int unsigned      next_slot;

  rsp_t        rsp_queue [$];
  int unsigned fails;

  assign fail_count_o = fails;
  assign pending_o    = rsp_queue.size();

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    fails++;
  endtask

  task automatic table_reset();
    for (int i = 0; i < DirEntries; i++) begin
      dir_present[i] = 1'b0;
      dir_user[i]    = 1'b0;
      dir_slot[i]    = '0;
    end
    for (int i = 0; i < TableSlots*TblEntries; i++) begin
      pte_mem[i] = (i < TblEntries) ? 32'((i << 12) | 32'h3) : 32'h0;
    end
    dir_present[0] = 1'b1;
    next_slot = 1;
  endtask

  // page walk result for one page of a range
  function automatic logic page_user_ok(input logic [31:0] addr);
    logic [9:0]  d;
    logic [31:0] pte;
    d = addr[31:22];
    if (!dir_present[d] || !dir_user[d]) return 1'b0;
    pte = pte_mem[{dir_slot[d], addr[21:12]}];
    return pte[0] && pte[2];
  endfunction

  task automatic apply_command(input req_t r, output rsp_t res);
    logic [9:0]  d;
    int unsigned idx;
    logic [31:0] addr, last_pg;
    res = '0;
    d = r.virt_addr[31:22];
    case (r.command)
      CmdMap: begin
        logic go;
        go = 1'b1;
        if (!dir_present[d]) begin
          if (r.new_table_frame == 0 || next_slot >= TableSlots) begin
            res.status = StNoTable;
            go = 1'b0;
          end else begin
            dir_present[d] = 1'b1;
            dir_user[d]    = r.page_flags[2];
            dir_slot[d]    = next_slot[SlotW-1:0];
            for (int i = 0; i < TblEntries; i++) pte_mem[next_slot*TblEntries + i] = '0;
            next_slot++;
            res.table_frame_used = 1'b1;
          end
        end else if (r.page_flags[2]) begin
          dir_user[d] = 1'b1;
        end
        if (go) begin
          idx = {dir_slot[d], r.virt_addr[21:12]};
          pte_mem[idx] = {r.phys_addr[31:12], 12'h0} | {20'h0, r.page_flags} | 32'h1;
        end
      end
      CmdUnmap: begin
        idx = {dir_slot[d], r.virt_addr[21:12]};
        if (!dir_present[d] || !pte_mem[idx][0]) begin
          res.status = StNotThere;
        end else begin
          res.freed_frame      = pte_mem[idx][31:12];
          res.free_frame_valid = 1'b1;
          res.inval_req        = 1'b1;
          pte_mem[idx]         = '0;
        end
      end
      CmdCheck: begin
        if (r.range_length == 0) begin
          res.range_ok = 1'b1;
        end else if (r.virt_addr + r.range_length < r.virt_addr) begin
          res.range_ok = 1'b0;
        end else begin
          addr    = {r.virt_addr[31:12], 12'h0};
          last_pg = (r.virt_addr + r.range_length - 1) & 32'hFFFF_F000;
          res.range_ok = 1'b1;
          forever begin
            if (!page_user_ok(addr)) begin
              res.range_ok = 1'b0;
              break;
            end
            if (addr == last_pg) break;
            addr += 32'h1000;
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t exp_rsp;
    rsp_t got;
    if (!rst_ni) begin
      table_reset();
      rsp_queue.delete();
      fails = 0;
    end else begin
      // new item first, its result cannot come in the same cycle
      if (req_valid_i && req_ready_i) begin
        apply_command(req_i, exp_rsp);
        rsp_queue.push_back(exp_rsp);
      end
      if (rsp_valid_i && rsp_ready_i) begin
        got = rsp_i;
        if (rsp_queue.size() == 0) begin
          report_mismatch("unexpected result", 32'(got), 32'h0);
        end else begin
          exp_rsp = rsp_queue.pop_front();
          if (got.status !== exp_rsp.status)
            report_mismatch("status", got.status, exp_rsp.status);
          if (got.range_ok !== exp_rsp.range_ok)
            report_mismatch("range_ok", got.range_ok, exp_rsp.range_ok);
          if (got.table_frame_used !== exp_rsp.table_frame_used)
            report_mismatch("table_frame_used", got.table_frame_used,
                            exp_rsp.table_frame_used);
          if (got.free_frame_valid !== exp_rsp.free_frame_valid)
            report_mismatch("free_frame_valid", got.free_frame_valid,
                            exp_rsp.free_frame_valid);
          if (got.freed_frame !== exp_rsp.freed_frame)
            report_mismatch("freed_frame", got.freed_frame, exp_rsp.freed_frame);
          if (got.inval_req !== exp_rsp.inval_req)
            report_mismatch("inval_req", got.inval_req, exp_rsp.inval_req);
        end
      end
    end
  end

endmodule

>>> test/two_level_page_table_manager_tb.sv
// testbench top: stimulus, idling phases and verdict for the page table manager
`timescale 1ns / 1ps
module two_level_page_table_manager_tb;
  import tlpt_pkg::*;

  // command code with no operation behind it
  localparam logic [1:0] CmdUnused = 2'd3;
  localparam int unsigned PhaseItems = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        req_valid = 1'b0;
  logic        req_ready;
  req_t        req = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  rsp_t        rsp;
  int unsigned fail_count;
  int unsigned pending;

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned items_sent;
  logic [9:0]  dir_pool [12];

  always #2 clk_i = ~clk_i;

  two_level_page_table_manager i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp)
  );

  tlpt_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_valid),
    .req_ready_i  (req_ready),
    .req_i        (req),
    .rsp_valid_i  (rsp_valid),
    .rsp_ready_i  (rsp_ready),
    .rsp_i        (rsp),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // receiver stalls at random, one decision per cycle
  always @(posedge clk_i) begin
    if (rst_ni) rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  function automatic req_t make_item(input logic [1:0] cmd, input logic [31:0] va,
                                     input logic [31:0] pa, input logic [11:0] flags,
                                     input logic [31:0] len, input logic [19:0] frame);
    req_t r;
    r.command         = cmd;
    r.virt_addr       = va;
    r.phys_addr       = pa;
    r.page_flags      = flags;
    r.range_length    = len;
    r.new_table_frame = frame;
    return r;
  endfunction

  // send_item only lowers valid when a gap is taken, so back-to-back items keep it high
  task automatic send_item(input req_t r);
    if ($urandom_range(99) < tx_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk_i); while (!req_ready);
    items_sent++;
  endtask

  // hold off the sender until every outstanding result has come back
  task automatic drain();
    req_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // mostly addresses inside a few directory entries so maps, unmaps and checks meet
  function automatic logic [31:0] pick_addr();
    if ($urandom_range(19) == 0) return $urandom;
    return {dir_pool[$urandom_range(11)], 6'($urandom_range(15)), 4'h0, 12'($urandom)};
  endfunction

  function automatic req_t random_item();
    logic [31:0] len;
    logic [19:0] frame;
    logic [11:0] flags;
    int unsigned sel;
    sel   = $urandom_range(99);
    flags = 12'($urandom);
    if ($urandom_range(2) != 0) flags[2] = 1'b1;
    frame = ($urandom_range(9) == 0) ? 20'h0 : 20'($urandom);
    case ($urandom_range(9))
      0:       len = $urandom;
      1:       len = 32'h0;
      default: len = $urandom_range(20 * 4096);
    endcase
    if (sel < 40) return make_item(CmdMap, pick_addr(), $urandom, flags, $urandom, frame);
    if (sel < 65) return make_item(CmdUnmap, pick_addr(), $urandom, flags, $urandom, frame);
    if (sel < 97) return make_item(CmdCheck, pick_addr(), $urandom, flags, len, frame);
    return make_item(CmdUnused, $urandom, $urandom, flags, $urandom, frame);
  endfunction

  initial begin
    tx_idle_pct = 10;
    rx_idle_pct = 73;
    items_sent  = 0;
    foreach (dir_pool[i]) dir_pool[i] = 10'($urandom);
    dir_pool[0] = 10'd0;
    dir_pool[1] = 10'd1023;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: kernel map, drop cases, fresh tables, range edges
    send_item(make_item(CmdCheck, 32'h0, '0, '0, 32'h1000, '0));        // kernel not user
    send_item(make_item(CmdCheck, 32'hFFFF_FFFF, '0, '0, 32'h0, '0));   // empty range
    send_item(make_item(CmdCheck, 32'hFFFF_F000, '0, '0, 32'h2000, '0)); // wraps
    send_item(make_item(CmdUnmap, 32'h003F_F000, '0, '0, '0, '0));      // kernel page freed
    send_item(make_item(CmdUnmap, 32'h003F_F000, '0, '0, '0, '0));      // now absent
    send_item(make_item(CmdUnmap, 32'hFFC0_0000, '0, '0, '0, '0));      // no table
    send_item(make_item(CmdMap, 32'hFFC0_0000, 32'hFFFF_FFFF, 12'h004, '0, '0)); // no frame
    send_item(make_item(CmdMap, 32'hFFFF_F000, 32'hFFFF_FFFF, 12'hFFE, '0, 20'hFFFFF));
    send_item(make_item(CmdCheck, 32'hFFFF_F000, '0, '0, 32'h1000, '0));
    send_item(make_item(CmdCheck, 32'hFFFF_F000, '0, '0, 32'h1001, '0));
    send_item(make_item(CmdMap, 32'h0000_5000, 32'h1234_5000, 12'h000, '0, 20'h1)); // kernel
    send_item(make_item(CmdMap, 32'h0000_6000, 32'h0, 12'h004, '0, 20'h1)); // pde gains user
    send_item(make_item(CmdCheck, 32'h0000_6FFF, '0, '0, 32'h1, '0));
    send_item(make_item(CmdUnmap, 32'h0000_5000, '0, '0, '0, '0));
    send_item(make_item(CmdMap, 32'h0040_0000, 32'h0, 12'h000, 32'hFFFF_FFFF, 20'h2));
    send_item(make_item(CmdCheck, 32'h0040_0000, '0, '0, 32'h1000, '0)); // pde not user
    send_item(make_item(CmdUnused, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF, 32'hFFFF_FFFF,
                        20'hFFFFF));
    for (int i = 0; i < 6; i++)  // use up the slot pool
      send_item(make_item(CmdMap, {10'd512 + 10'(i), 22'h0}, 32'h0, 12'h007, '0, 20'h10));
    send_item(make_item(CmdMap, 32'h8400_0000, 32'h0, 12'h007, '0, 20'h10)); // pool empty
    drain();

    // random, three idling phases with a full drain between them
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        tx_idle_pct = 73;
        rx_idle_pct = 10;
      end else if (ph == 2) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      for (int n = 0; n < PhaseItems; n++) send_item(random_item());
      drain();
    end

    repeat (20) @(posedge clk_i);
    $display("ran %0d items: maps with table allocation and pool exhaustion,", items_sent);
    $display("unmaps, range checks incl. empty and wrapping, under three stall mixes");
    if (fail_count == 0) begin
      $display("PASS two_level_page_table_manager");
    end else begin
      $display("FAIL two_level_page_table_manager");
    end
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("FAIL two_level_page_table_manager");
    $finish;
  end

endmodule
